// File: rtl/sep_pkg.sv
// shared types, constants and helper functions of the spark emitter pool
package sep_pkg;

    localparam int EMITTER_SLOTS  = 16;
    localparam int SPARK_SLOTS    = 64;
    localparam int ROW_COUNT      = 32;
    localparam int SPARK_LIFETIME = 32;
    localparam int MAX_RESULTS    = 64;

    localparam int EID_W = 4;
    localparam int SID_W = 6;
    localparam int ROW_W = 5;
    localparam int CNT_W = 7;

    localparam int FL_USED    = 6;
    localparam int FL_DESTROY = 7;

    localparam logic [2:0] CMD_CREATE  = 3'd0;
    localparam logic [2:0] CMD_ADD     = 3'd1;
    localparam logic [2:0] CMD_DESTROY = 3'd2;
    localparam logic [2:0] CMD_TICK    = 3'd3;
    localparam logic [2:0] CMD_QUERY   = 3'd4;

    localparam logic [1:0] KIND_CREATE  = 2'd0;
    localparam logic [1:0] KIND_SEGMENT = 2'd1;
    localparam logic [1:0] KIND_NONE    = 2'd2;

    typedef struct packed {
        logic [2:0]         cmd;
        logic [5:0]         dir_flags;
        logic [7:0]         row;
        logic [23:0]        tint;
        logic [3:0]         emitter_id;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [5:0]         rand_dx;
        logic [5:0]         rand_dy;
        logic [5:0]         rand_dz;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [3:0]         slot;
        logic signed [31:0] head_x;
        logic signed [31:0] head_y;
        logic signed [31:0] head_z;
        logic signed [31:0] tail_x;
        logic signed [31:0] tail_y;
        logic signed [31:0] tail_z;
        logic [23:0]        shade;
        logic               last;
    } out_item_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [7:0]  vel_x;
        logic signed [7:0]  vel_y;
        logic signed [7:0]  vel_z;
        logic [7:0]         life;
    } spark_rec_t;

    localparam int REC_W = $bits(spark_rec_t);

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_CR_SRCH,
        S_CR_DONE,
        S_AD_RD,
        S_AD_WR,
        S_TK_EMIT,
        S_TK_RRD,
        S_TK_REAP,
        S_TK_UNL,
        S_TK_AFTER,
        S_TK_ROW,
        S_TK_MRD,
        S_TK_MOVE,
        S_Q_EMIT,
        S_Q_RD,
        S_Q_OUT,
        S_Q_END
    } state_t;

    typedef struct packed {
        state_t st;
    } ctl_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic       row_ok;
        logic       add_ok;
        logic       srch_stop;
        logic       e_used;
        logic       head_zero;
        logic       nx_zero;
        logic       life_zero;
        logic       prev_zero;
        logic       cur_zero;
        logic       kill;
        logic       row_done;
        logic       tk_next_e;
        logic       e_last;
        logic       e_zero;
        logic       k_last;
    } stat_t;

    // new velocity from a random value and the sign clamp of its axis
    function automatic logic signed [7:0] mk_vel(logic [5:0] r, logic pos_f, logic neg_f);
        logic signed [7:0] v;
        logic signed [7:0] a;
        v = $signed({2'b00, r}) - 8'sd31;
        a = (v < 0) ? -v : v;
        if (pos_f)
            v = a;
        if (neg_f)
            v = -a;
        return v;
    endfunction

    // dy plus gravity, held within -127..127
    function automatic logic signed [7:0] grav_vel(logic signed [7:0] v, logic signed [4:0] g);
        logic signed [8:0] s;
        s = 9'(v) + 9'(g);
        if (s < -9'sd127)
            s = -9'sd127;
        if (s > 9'sd127)
            s = 9'sd127;
        return s[7:0];
    endfunction

    // position plus velocity arithmetically shifted right
    function automatic logic signed [31:0] add_asr(logic signed [31:0] p, logic signed [7:0] v,
                                                   logic [1:0] sh);
        logic signed [7:0] d;
        d = v >>> sh;
        return p + 32'(d);
    endfunction

    // one colour channel scaled by remaining life
    function automatic logic [7:0] fade(logic [7:0] ch, logic [7:0] life);
        logic [15:0] prod;
        prod = 16'(ch) * 16'(life);
        prod = prod / 16'(SPARK_LIFETIME);
        return prod[7:0];
    endfunction

endpackage

// File: rtl/spark_emitter_pool.sv
// top level of the spark emitter pool: controller plus datapath
//
// usage
//   - an item (create, add, destroy, tick or query) is taken when start is
//     high and busy is low; busy stays high until its work is done
//   - results come out on result with result_valid high for exactly one
//     cycle each; the receiver cannot stall, so results are never held
//   - result.last marks the final result of an item
//   - cfg_we writes gravity_step from cfg_data, only while idle; the block itself does not enforce this
// work per item
//   - create: round-robin slot search up to the result strobe, one
//     slot a cycle
//   - add: a read state then a write state, unless ignored; destroy and
//     ignored codes end after decode
//   - tick: a pass over every emitter, a reaping walk over its sparks,
//     then a move of each spark or a walk of the row entries on an unlink;
//     the spark ram has a single read port
//   - query: results follow through a one-entry holding register
// reset
//   - all emitters free, rows empty, spark free list 1..63 in order; the
//     free list links come from per-entry valid bits, so no clearing pass
module spark_emitter_pool (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  sep_pkg::in_item_t  item,
    input  logic               cfg_we,
    input  logic [4:0]         cfg_data,
    output logic               result_valid,
    output sep_pkg::out_item_t result
);

    // command from controller, status back from datapath
    sep_pkg::ctl_t  ctl;
    sep_pkg::stat_t stat;

    sep_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .ctl   (ctl),
        .busy  (busy)
    );

    sep_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .ctl          (ctl),
        .stat         (stat),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

// File: rtl/sep_ram.sv
// generic simple dual-port ram with registered read
module sep_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/sep_ctrl.sv
// controller state machine of the spark emitter pool
module sep_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  sep_pkg::stat_t stat,
    output sep_pkg::ctl_t ctl,
    output logic          busy
);

    sep_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sep_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sep_pkg::S_IDLE:
            begin
                if (start)
                    state_next = sep_pkg::S_DECODE;
            end
            sep_pkg::S_DECODE:
            begin
                unique case (stat.cmd)
                    sep_pkg::CMD_CREATE:
                        state_next = stat.row_ok ? sep_pkg::S_CR_SRCH : sep_pkg::S_CR_DONE;
                    sep_pkg::CMD_ADD:
                        state_next = stat.add_ok ? sep_pkg::S_AD_RD : sep_pkg::S_IDLE;
                    sep_pkg::CMD_TICK:
                        state_next = sep_pkg::S_TK_EMIT;
                    sep_pkg::CMD_QUERY:
                        state_next = stat.row_ok ? sep_pkg::S_Q_EMIT : sep_pkg::S_Q_END;
                    default:
                        state_next = sep_pkg::S_IDLE;
                endcase
            end
            sep_pkg::S_CR_SRCH:
            begin
                if (stat.srch_stop)
                    state_next = sep_pkg::S_CR_DONE;
            end
            sep_pkg::S_CR_DONE:  state_next = sep_pkg::S_IDLE;
            sep_pkg::S_AD_RD:    state_next = sep_pkg::S_AD_WR;
            sep_pkg::S_AD_WR:    state_next = sep_pkg::S_IDLE;
            sep_pkg::S_TK_EMIT:
            begin
                if (stat.tk_next_e)
                    state_next = stat.e_last ? sep_pkg::S_IDLE : sep_pkg::S_TK_EMIT;
                else
                    state_next = stat.head_zero ? sep_pkg::S_TK_AFTER : sep_pkg::S_TK_RRD;
            end
            sep_pkg::S_TK_RRD:   state_next = sep_pkg::S_TK_REAP;
            sep_pkg::S_TK_REAP:
            begin
                if (stat.life_zero && !stat.prev_zero)
                    state_next = sep_pkg::S_TK_UNL;
                else
                    state_next = stat.nx_zero ? sep_pkg::S_TK_AFTER : sep_pkg::S_TK_RRD;
            end
            sep_pkg::S_TK_UNL:
                state_next = stat.cur_zero ? sep_pkg::S_TK_AFTER : sep_pkg::S_TK_RRD;
            sep_pkg::S_TK_AFTER:
            begin
                if (stat.tk_next_e)
                    state_next = stat.e_last ? sep_pkg::S_IDLE : sep_pkg::S_TK_EMIT;
                else
                    state_next = stat.kill ? sep_pkg::S_TK_ROW : sep_pkg::S_TK_MRD;
            end
            sep_pkg::S_TK_ROW:
            begin
                if (stat.tk_next_e)
                    state_next = stat.e_last ? sep_pkg::S_IDLE : sep_pkg::S_TK_EMIT;
            end
            sep_pkg::S_TK_MRD:   state_next = sep_pkg::S_TK_MOVE;
            sep_pkg::S_TK_MOVE:
            begin
                if (stat.tk_next_e)
                    state_next = stat.e_last ? sep_pkg::S_IDLE : sep_pkg::S_TK_EMIT;
                else
                    state_next = sep_pkg::S_TK_MRD;
            end
            sep_pkg::S_Q_EMIT:
            begin
                if (stat.e_zero)
                    state_next = sep_pkg::S_Q_END;
                else if (!stat.head_zero)
                    state_next = sep_pkg::S_Q_RD;
            end
            sep_pkg::S_Q_RD:     state_next = sep_pkg::S_Q_OUT;
            sep_pkg::S_Q_OUT:
            begin
                if (stat.k_last)
                    state_next = sep_pkg::S_Q_END;
                else
                    state_next = stat.nx_zero ? sep_pkg::S_Q_EMIT : sep_pkg::S_Q_RD;
            end
            sep_pkg::S_Q_END:    state_next = sep_pkg::S_IDLE;
            default:             state_next = sep_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        ctl.st = state_reg;
        busy   = (state_reg != sep_pkg::S_IDLE);
    end

endmodule

// File: rtl/sep_datapath.sv
// storage, chain walking and result datapath of the spark emitter pool
module sep_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  sep_pkg::in_item_t item,
    input  logic              cfg_we,
    input  logic [4:0]        cfg_data,
    input  sep_pkg::ctl_t     ctl,
    output sep_pkg::stat_t    stat,
    output logic              result_valid,
    output sep_pkg::out_item_t result
);

    localparam int EW = sep_pkg::EID_W;
    localparam int SW = sep_pkg::SID_W;
    localparam int RW = sep_pkg::ROW_W;

    sep_pkg::in_item_t  item_reg;
    logic signed [4:0]  grav_reg;
    logic [EW-1:0]      rr_reg, rr_next;
    logic [SW-1:0]      free_head_reg, free_head_next;
    logic [EW-1:0]      found_reg, found_next;
    logic [EW-1:0]      cnt_reg, cnt_next;
    logic [EW-1:0]      e_reg, e_next;
    logic [SW-1:0]      cur_reg, cur_next;
    logic [SW-1:0]      prev_reg, prev_next;
    logic [SW-1:0]      nx_reg, nx_next;
    logic [EW-1:0]      c_reg, c_next;
    logic [EW-1:0]      p_reg, p_next;
    logic [sep_pkg::CNT_W-1:0] k_reg, k_next;
    sep_pkg::out_item_t pend_reg, pend_next;
    logic               pend_vld_reg, pend_vld_next;
    sep_pkg::out_item_t res_reg, res_next;
    logic               res_vld_reg, res_vld_next;

    // emitter store
    logic [7:0]    eflags_reg [sep_pkg::EMITTER_SLOTS];
    logic [23:0]   etint_reg  [sep_pkg::EMITTER_SLOTS];
    logic [RW-1:0] erow_reg   [sep_pkg::EMITTER_SLOTS];
    logic [EW-1:0] elink_reg  [sep_pkg::EMITTER_SLOTS];
    logic [SW-1:0] eshead_reg [sep_pkg::EMITTER_SLOTS];
    logic [EW-1:0] row_head_reg [sep_pkg::ROW_COUNT];

    // spark link store valid bits
    logic [sep_pkg::SPARK_SLOTS-1:0] lk_vld_reg;
    logic          lk_vq_reg;
    logic [SW-1:0] lk_aq_reg;

    // ram ports
    logic          rec_we, lk_we;
    logic [SW-1:0] rec_waddr, lk_waddr, lk_raddr;
    sep_pkg::spark_rec_t rec_wdata, rec_rd;
    logic [SW-1:0] lk_wdata, lk_ram_q, lk_rd;
    logic [sep_pkg::REC_W-1:0] rec_q;

    // emitter write controls
    logic          cr_wr, dst_wr, kill_wr, sh_wr, el_wr, rh_wr;
    logic [EW-1:0] sh_addr, el_addr;
    logic [SW-1:0] sh_data;
    logic [EW-1:0] el_data, rh_data;
    logic [RW-1:0] rh_addr;

    sep_pkg::state_t st;
    logic [EW-1:0] id;
    logic [RW-1:0] row5;
    logic          row_ok;
    logic [EW-1:0] rr_wrap;
    logic          rr_free;
    logic          e_used, head_zero, kill, life_zero, nx_zero;
    logic          c_hit, row_done, tk_next_e;
    logic [RW-1:0] er;
    sep_pkg::spark_rec_t new_rec, mov_rec;
    sep_pkg::out_item_t  seg;
    logic signed [7:0]   dy_new;

    sep_ram #(.WIDTH(sep_pkg::REC_W), .DEPTH(sep_pkg::SPARK_SLOTS)) u_rec_ram (
        .clk   (clk),
        .we    (rec_we),
        .waddr (rec_waddr),
        .wdata (rec_wdata),
        .raddr (cur_reg),
        .rdata (rec_q)
    );

    sep_ram #(.WIDTH(SW), .DEPTH(sep_pkg::SPARK_SLOTS)) u_link_ram (
        .clk   (clk),
        .we    (lk_we),
        .waddr (lk_waddr),
        .wdata (lk_wdata),
        .raddr (lk_raddr),
        .rdata (lk_ram_q)
    );

    assign rec_rd = sep_pkg::spark_rec_t'(rec_q);
    // never written entries link to the next slot
    assign lk_rd  = lk_vq_reg ? lk_ram_q :
                    ((lk_aq_reg == SW'(sep_pkg::SPARK_SLOTS - 1)) ? '0 : lk_aq_reg + 1'b1);

    always_comb
    begin
        st        = ctl.st;
        id        = item_reg.emitter_id;
        row5      = item_reg.row[RW-1:0];
        row_ok    = (item_reg.row < 8'(sep_pkg::ROW_COUNT));
        rr_wrap   = (rr_reg == EW'(sep_pkg::EMITTER_SLOTS - 1)) ? EW'(1) : rr_reg + 1'b1;
        rr_free   = !eflags_reg[rr_wrap][sep_pkg::FL_USED];
        e_used    = eflags_reg[e_reg][sep_pkg::FL_USED];
        head_zero = (eshead_reg[e_reg] == '0);
        kill      = eflags_reg[e_reg][sep_pkg::FL_DESTROY] && head_zero;
        life_zero = (rec_rd.life == '0);
        nx_zero   = (lk_rd == '0);
        er        = erow_reg[e_reg];
        c_hit     = (c_reg == e_reg);
        row_done  = (c_reg == '0) || c_hit;
        tk_next_e = ((st == sep_pkg::S_TK_EMIT) && !e_used)
                 || ((st == sep_pkg::S_TK_AFTER) && !kill && head_zero)
                 || ((st == sep_pkg::S_TK_ROW) && row_done)
                 || ((st == sep_pkg::S_TK_MOVE) && nx_zero);

        new_rec.pos_x = item_reg.pos_x;
        new_rec.pos_y = item_reg.pos_y;
        new_rec.pos_z = item_reg.pos_z;
        new_rec.vel_x = sep_pkg::mk_vel(item_reg.rand_dx, eflags_reg[id][0], eflags_reg[id][1]);
        new_rec.vel_y = sep_pkg::mk_vel(item_reg.rand_dy, eflags_reg[id][2], eflags_reg[id][3]);
        new_rec.vel_z = sep_pkg::mk_vel(item_reg.rand_dz, eflags_reg[id][4], eflags_reg[id][5]);
        new_rec.life  = 8'(sep_pkg::SPARK_LIFETIME);

        dy_new        = sep_pkg::grav_vel(rec_rd.vel_y, grav_reg);
        mov_rec.vel_x = rec_rd.vel_x;
        mov_rec.vel_y = dy_new;
        mov_rec.vel_z = rec_rd.vel_z;
        mov_rec.pos_x = sep_pkg::add_asr(rec_rd.pos_x, rec_rd.vel_x, 2'd3);
        mov_rec.pos_y = sep_pkg::add_asr(rec_rd.pos_y, dy_new, 2'd3);
        mov_rec.pos_z = sep_pkg::add_asr(rec_rd.pos_z, rec_rd.vel_z, 2'd3);
        mov_rec.life  = life_zero ? rec_rd.life : rec_rd.life - 1'b1;

        seg.kind   = sep_pkg::KIND_SEGMENT;
        seg.slot   = '0;
        seg.head_x = rec_rd.pos_x;
        seg.head_y = rec_rd.pos_y;
        seg.head_z = rec_rd.pos_z;
        seg.tail_x = sep_pkg::add_asr(rec_rd.pos_x, rec_rd.vel_x, 2'd2);
        seg.tail_y = sep_pkg::add_asr(rec_rd.pos_y, rec_rd.vel_y, 2'd2);
        seg.tail_z = sep_pkg::add_asr(rec_rd.pos_z, rec_rd.vel_z, 2'd2);
        seg.shade  = {sep_pkg::fade(etint_reg[e_reg][23:16], rec_rd.life),
                      sep_pkg::fade(etint_reg[e_reg][15:8], rec_rd.life),
                      sep_pkg::fade(etint_reg[e_reg][7:0], rec_rd.life)};
        seg.last   = 1'b0;
    end

    always_comb
    begin
        stat.cmd       = item_reg.cmd;
        stat.row_ok    = row_ok;
        stat.add_ok    = (id != '0) && eflags_reg[id][sep_pkg::FL_USED] && (free_head_reg != '0);
        stat.srch_stop = rr_free || (cnt_reg == EW'(sep_pkg::EMITTER_SLOTS - 1));
        stat.e_used    = e_used;
        stat.head_zero = head_zero;
        stat.nx_zero   = nx_zero;
        stat.life_zero = life_zero;
        stat.prev_zero = (prev_reg == '0);
        stat.cur_zero  = (cur_reg == '0);
        stat.kill      = kill;
        stat.row_done  = row_done;
        stat.tk_next_e = tk_next_e;
        stat.e_last    = (e_reg == EW'(sep_pkg::EMITTER_SLOTS - 1));
        stat.e_zero    = (e_reg == '0);
        stat.k_last    = (k_reg == sep_pkg::CNT_W'(sep_pkg::MAX_RESULTS - 1));
    end

    always_comb
    begin
        rr_next        = rr_reg;
        free_head_next = free_head_reg;
        found_next     = found_reg;
        cnt_next       = cnt_reg;
        e_next         = e_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        nx_next        = nx_reg;
        c_next         = c_reg;
        p_next         = p_reg;
        k_next         = k_reg;
        pend_next      = pend_reg;
        pend_vld_next  = pend_vld_reg;
        res_next       = res_reg;
        res_vld_next   = 1'b0;

        rec_we    = 1'b0;
        rec_waddr = cur_reg;
        rec_wdata = mov_rec;
        lk_we     = 1'b0;
        lk_waddr  = cur_reg;
        lk_wdata  = free_head_reg;
        lk_raddr  = (st == sep_pkg::S_AD_RD) ? free_head_reg : cur_reg;

        cr_wr   = 1'b0;
        dst_wr  = 1'b0;
        kill_wr = 1'b0;
        sh_wr   = 1'b0;
        sh_addr = e_reg;
        sh_data = lk_rd;
        el_wr   = 1'b0;
        el_addr = p_reg;
        el_data = elink_reg[e_reg];
        rh_wr   = 1'b0;
        rh_addr = er;
        rh_data = elink_reg[e_reg];

        if (tk_next_e)
            e_next = e_reg + 1'b1;

        unique case (st)
            sep_pkg::S_DECODE:
            begin
                found_next    = '0;
                cnt_next      = '0;
                k_next        = '0;
                pend_vld_next = 1'b0;
                e_next        = (item_reg.cmd == sep_pkg::CMD_TICK) ? EW'(1) : row_head_reg[row5];
                dst_wr        = (item_reg.cmd == sep_pkg::CMD_DESTROY) && (id != '0)
                              && eflags_reg[id][sep_pkg::FL_USED];
            end
            sep_pkg::S_CR_SRCH:
            begin
                rr_next  = rr_wrap;
                cnt_next = cnt_reg + 1'b1;
                if (rr_free)
                    found_next = rr_wrap;
            end
            sep_pkg::S_CR_DONE:
            begin
                cr_wr         = (found_reg != '0);
                rh_addr       = row5;
                rh_data       = found_reg;
                rh_wr         = cr_wr;
                res_next      = '0;
                res_next.kind = sep_pkg::KIND_CREATE;
                res_next.slot = found_reg;
                res_next.last = 1'b1;
                res_vld_next  = 1'b1;
            end
            sep_pkg::S_AD_WR:
            begin
                free_head_next = lk_rd;
                rec_we    = 1'b1;
                rec_waddr = free_head_reg;
                rec_wdata = new_rec;
                lk_we     = 1'b1;
                lk_waddr  = free_head_reg;
                lk_wdata  = eshead_reg[id];
                sh_wr     = 1'b1;
                sh_addr   = id;
                sh_data   = free_head_reg;
            end
            sep_pkg::S_TK_EMIT:
            begin
                cur_next  = eshead_reg[e_reg];
                prev_next = '0;
            end
            sep_pkg::S_TK_REAP:
            begin
                nx_next  = lk_rd;
                cur_next = lk_rd;
                if (life_zero)
                begin
                    lk_we          = 1'b1;
                    free_head_next = cur_reg;
                    sh_wr          = (prev_reg == '0);
                end
                else
                begin
                    prev_next = cur_reg;
                end
            end
            sep_pkg::S_TK_UNL:
            begin
                lk_we    = 1'b1;
                lk_waddr = prev_reg;
                lk_wdata = nx_reg;
            end
            sep_pkg::S_TK_AFTER:
            begin
                cur_next = eshead_reg[e_reg];
                c_next   = row_head_reg[er];
                p_next   = '0;
                kill_wr  = kill;
            end
            sep_pkg::S_TK_ROW:
            begin
                if (c_hit)
                begin
                    rh_wr = (p_reg == '0);
                    el_wr = (p_reg != '0);
                end
                else if (c_reg != '0)
                begin
                    p_next = c_reg;
                    c_next = elink_reg[c_reg];
                end
            end
            sep_pkg::S_TK_MOVE:
            begin
                rec_we   = 1'b1;
                cur_next = lk_rd;
            end
            sep_pkg::S_Q_EMIT:
            begin
                cur_next = eshead_reg[e_reg];
                if (head_zero)
                    e_next = elink_reg[e_reg];
            end
            sep_pkg::S_Q_OUT:
            begin
                if (pend_vld_reg)
                begin
                    res_next     = pend_reg;
                    res_vld_next = 1'b1;
                end
                pend_next     = seg;
                pend_vld_next = 1'b1;
                k_next        = k_reg + 1'b1;
                cur_next      = lk_rd;
                if (nx_zero)
                    e_next = elink_reg[e_reg];
            end
            sep_pkg::S_Q_END:
            begin
                if (pend_vld_reg)
                begin
                    res_next = pend_reg;
                end
                else
                begin
                    res_next      = '0;
                    res_next.kind = sep_pkg::KIND_NONE;
                end
                res_next.last = 1'b1;
                res_vld_next  = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grav_reg      <= -5'sd1;
            rr_reg        <= EW'(1);
            free_head_reg <= SW'(1);
            found_reg     <= '0;
            cnt_reg       <= '0;
            e_reg         <= '0;
            cur_reg       <= '0;
            prev_reg      <= '0;
            nx_reg        <= '0;
            c_reg         <= '0;
            p_reg         <= '0;
            k_reg         <= '0;
            pend_vld_reg  <= 1'b0;
            res_vld_reg   <= 1'b0;
            lk_vld_reg    <= '0;
            lk_vq_reg     <= 1'b0;
            for (int i = 0; i < sep_pkg::EMITTER_SLOTS; i++)
            begin
                eflags_reg[i] <= '0;
            end
            for (int i = 0; i < sep_pkg::ROW_COUNT; i++)
            begin
                row_head_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
                grav_reg <= $signed(cfg_data);
            rr_reg        <= rr_next;
            free_head_reg <= free_head_next;
            found_reg     <= found_next;
            cnt_reg       <= cnt_next;
            e_reg         <= e_next;
            cur_reg       <= cur_next;
            prev_reg      <= prev_next;
            nx_reg        <= nx_next;
            c_reg         <= c_next;
            p_reg         <= p_next;
            k_reg         <= k_next;
            pend_vld_reg  <= pend_vld_next;
            res_vld_reg   <= res_vld_next;
            lk_vq_reg     <= lk_vld_reg[lk_raddr];
            if (lk_we)
                lk_vld_reg[lk_waddr] <= 1'b1;
            if (cr_wr)
                eflags_reg[found_reg] <= {1'b0, 1'b1, item_reg.dir_flags};
            if (dst_wr)
                eflags_reg[id][sep_pkg::FL_DESTROY] <= 1'b1;
            if (kill_wr)
                eflags_reg[e_reg][sep_pkg::FL_USED] <= 1'b0;
            if (rh_wr)
                row_head_reg[rh_addr] <= rh_data;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (start && !busy)
            item_reg <= item;
        pend_reg  <= pend_next;
        res_reg   <= res_next;
        lk_aq_reg <= lk_raddr;
        if (cr_wr)
        begin
            etint_reg[found_reg]  <= item_reg.tint;
            erow_reg[found_reg]   <= row5;
            elink_reg[found_reg]  <= row_head_reg[row5];
            eshead_reg[found_reg] <= '0;
        end
        if (sh_wr)
            eshead_reg[sh_addr] <= sh_data;
        if (el_wr)
            elink_reg[el_addr] <= el_data;
    end

    assign result_valid = res_vld_reg;
    assign result       = res_reg;

    a_res_src: assert property (@(posedge clk) disable iff (!rst_n)
        res_vld_reg |-> ($past(st) == sep_pkg::S_CR_DONE || $past(st) == sep_pkg::S_Q_OUT
                         || $past(st) == sep_pkg::S_Q_END))
        else $error("result without a producing state");

    a_none_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res_vld_reg && res_reg.kind == sep_pkg::KIND_NONE) |-> res_reg.last)
        else $error("empty query answer not marked last");

    a_rr_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        rr_reg != '0)
        else $error("round-robin pointer at slot 0");

    a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (res_vld_reg && res_reg.last) |-> !busy)
        else $error("final result while still busy");

endmodule
